// File: src/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// No dependencies; the bodies are empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TPS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define TPS_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// File: src/tps_pkg.sv
// Types and codes of the timed priority transmission scheduler.
// No dependencies.
package tps_pkg;
  localparam int unsigned CmdW = 3;
  localparam logic [CmdW-1:0] CMD_ADD        = 3'd0;
  localparam logic [CmdW-1:0] CMD_POP        = 3'd1;
  localparam logic [CmdW-1:0] CMD_CANCEL_ID  = 3'd2;
  localparam logic [CmdW-1:0] CMD_CANCEL_RCP = 3'd3;
  localparam logic [CmdW-1:0] CMD_CANCEL_ALL = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]  command;
    logic [63:0] time_us;
    logic [7:0]  priority_req;
    logic [19:0] duration_us;
    logic [31:0] repeat_us;
    logic [7:0]  recipient;
    logic [7:0]  packet_handle;
    logic [31:0] cancel_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] tx_id;
    logic [63:0] out_time_us;
    logic [7:0]  out_priority;
    logic [7:0]  out_recipient;
    logic [7:0]  out_handle;
    logic [4:0]  removed_count;
  } rsp_t;

  // One table entry as stored in memory
  typedef struct packed {
    logic [63:0] start;
    logic [19:0] dur;
    logic [7:0]  prio;
    logic [31:0] period;
    logic [7:0]  target;
    logic [7:0]  handle;
    logic [31:0] ident;
  } entry_t;

  function automatic logic [63:0] sat_end(logic [63:0] s, logic [19:0] d);
    logic [64:0] sum;
    sum = {1'b0, s} + {45'd0, d};
    return sum[64] ? '1 : sum[63:0];
  endfunction
endpackage

// File: src/tps_if.sv
// Valid/ready channel interfaces for scheduler items.
// Depends on tps_pkg.
interface tps_req_if import tps_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tps_rsp_if import tps_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/timed_priority_tx_scheduler_unit.sv
// Top level of the timed priority transmission scheduler: table in one memory,
// sequencer for add, pop and cancel. Depends on tps_pkg, tps_if, assert_macros.svh.
//
//  channel  | dir | payload
//  req      | in  | command, time, priority, duration, repeat, recipient, handle, id
//  rsp      | out | status, id, time, priority, recipient, handle, removed count
//
// One item at a time; the table memory read is registered. Pop and cancel scans
// read one entry a cycle; the add walk passes a wait state between reads. A pop of
// a repeating entry adds a remainder division and a reinsert walked like an add.
// Reset clears occupancy and the id counter; no memory clearing pass.
// A finished result waits in the output register while the next item is taken;
// the following result holds the sequencer in its last state until that register frees.
`include "assert_macros.svh"
module timed_priority_tx_scheduler_unit import tps_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  tps_req_if.sink   req,
  tps_rsp_if.source rsp
);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_FIND  = 11'b00000000010,  // walk for slot (read issued, compare data)
    S_SHIFT = 11'b00000000100,  // move entries up by one, from the top
    S_PUT   = 11'b00000001000,
    S_PSCAN = 11'b00000010000,  // pop: scan for ready entry
    S_PREM  = 11'b00000100000,  // remove at index, shifting down
    S_DIV   = 11'b00001000000,
    S_CSCAN = 11'b00010000000,  // cancel scan and compact
    S_DONE  = 11'b00100000000,
    S_RDWT  = 11'b01000000000,
    S_SHRD  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  req_t   cur_q;
  rsp_t   rsp_q;                   // result being built
  rsp_t   out_q;                   // result shown on the output
  logic   rsp_v_q;
  logic   pend_q;                  // a result is being built
  logic [CW-1:0] occ_q;
  logic [31:0]   idc_q;

  // table memory
  entry_t mem [TABLE_DEPTH];
  entry_t rd_q;
  logic [AW-1:0] ra, wa;
  logic          we;
  entry_t        wd;
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  // working registers
  logic [CW-1:0] i_q, j_q, pos_q, cnt_q;
  entry_t        ins_q;           // entry being inserted
  logic [63:0]   head_q;
  logic [255:0]  seen_q;
  logic [63:0]   rem_q;
  logic [63:0]   dvd_q;
  logic [6:0]    dstep_q;

  logic [AW-1:0] i_a, j_a;
  assign i_a = i_q[AW-1:0];
  assign j_a = j_q[AW-1:0];

  // insertion rule on the entry just read
  logic [63:0] rd_end, ins_end;
  logic        slot_hit;
  assign rd_end  = sat_end(rd_q.start, rd_q.dur);
  assign ins_end = sat_end(ins_q.start, ins_q.dur);
  always_comb begin
    if (ins_q.start < rd_q.start) slot_hit = (ins_end < rd_q.start) || (ins_q.prio <= rd_q.prio);
    else slot_hit = (ins_q.start < rd_end) && (ins_q.prio < rd_q.prio);
  end

  // divider step: restoring remainder of (now-start) by period
  logic [64:0] rtry;
  assign rtry = {rem_q, dvd_q[63]} - {33'd0, ins_q.period};

  // cancel match on the entry read
  logic rd_hit_c;
  assign rd_hit_c = (cur_q.command == CMD_CANCEL_ID) ? (rd_q.ident == cur_q.cancel_id)
                                                     : (rd_q.target == cur_q.recipient);

  logic take_req;
  logic out_free;
  assign req.ready = (state_q == S_IDLE) && !pend_q;
  assign take_req  = req.valid && req.ready;
  assign out_free  = !rsp_v_q || rsp.ready;
  assign rsp.valid = rsp_v_q;
  assign rsp.data  = out_q;

  logic [64:0] adv;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; rsp_v_q <= 1'b0; pend_q <= 1'b0;
      occ_q <= '0; idc_q <= '0;
    end else begin
      state_q <= state_d;
      if (take_req) pend_q <= 1'b1;
      if (state_q == S_DONE && out_free) begin
        rsp_v_q <= 1'b1; pend_q <= 1'b0;
      end else if (rsp.ready) rsp_v_q <= 1'b0;
      if (state_q == S_PUT) occ_q <= occ_q + 1'b1;
      if (state_q == S_PREM && !(j_q + 1'b1 < occ_q)) occ_q <= occ_q - 1'b1;
      if (state_q == S_IDLE && take_req && req.data.command == CMD_CANCEL_ALL) occ_q <= '0;
      if (state_q == S_IDLE && take_req && req.data.command == CMD_ADD && occ_q < CW'(TABLE_DEPTH))
        idc_q <= idc_q + 32'd1;
      if (state_q == S_CSCAN && i_q == occ_q) occ_q <= occ_q - cnt_q - CW'(rd_hit_c);
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q; ra = '0; wa = '0; we = 1'b0; wd = ins_q;
    adv = '0;
    unique case (state_q)
      S_IDLE: begin
        if (take_req) begin
          state_d = S_DONE;
          unique case (req.data.command)
            CMD_ADD: if (occ_q < CW'(TABLE_DEPTH)) state_d = (occ_q == '0) ? S_PUT : S_FIND;
            CMD_POP: if (occ_q != '0) state_d = S_PSCAN;
            CMD_CANCEL_ID, CMD_CANCEL_RCP: if (occ_q != '0) state_d = S_CSCAN;
            default: state_d = S_DONE;
          endcase
        end
        ra = '0;
      end
      S_FIND: begin
        // i_q: index whose data is in rd_q
        if (slot_hit) state_d = (occ_q == i_q) ? S_PUT : S_SHRD;
        else if (i_q + 1'b1 >= occ_q) state_d = S_PUT;
        else begin
          ra = AW'(i_q + 1'b1); state_d = S_RDWT;
        end
      end
      S_RDWT: begin
        ra = i_a; state_d = S_FIND;
      end
      S_SHRD: begin
        ra = AW'(j_q - 1'b1); state_d = S_SHIFT;
      end
      S_SHIFT: begin
        we = 1'b1; wa = j_a; wd = rd_q;
        state_d = (j_q - 1'b1 == pos_q) ? S_PUT : S_SHRD;
      end
      S_PUT: begin
        we = 1'b1; wa = pos_q[AW-1:0]; wd = ins_q; state_d = S_DONE;
      end
      S_PSCAN: begin
        if (i_q == '0) begin
          if (cur_q.time_us >= rd_q.start) state_d = S_PREM;
          else if (occ_q == CW'(1)) state_d = S_DONE;
          else begin
            ra = AW'(1); state_d = S_PSCAN;
          end
        end else if (cur_q.time_us >= rd_q.start && rd_end < head_q && !seen_q[rd_q.target]) begin
          state_d = S_PREM;
        end else if (i_q + 1'b1 >= occ_q) state_d = S_DONE;
        else ra = AW'(i_q + 1'b1);
        if (state_d == S_PREM) ra = AW'(i_q + 1'b1);
      end
      S_PREM: begin
        // rd_q holds entry j+1; write it to j
        if (j_q + 1'b1 < occ_q) begin
          we = 1'b1; wa = j_a; wd = rd_q; ra = AW'(j_q + 2'd2);
        end else if (ins_q.period != '0) state_d = S_DIV;
        else state_d = S_DONE;
      end
      S_DIV: begin
        if (dstep_q == 7'd64) begin
          if (ins_q.start == cur_q.time_us) adv = {1'b0, ins_q.start} + {33'd0, ins_q.period};
          else if (rem_q == '0) adv = {1'b0, cur_q.time_us};
          else adv = {1'b0, cur_q.time_us} + ({33'd0, ins_q.period} - {1'b0, rem_q});
          state_d = (occ_q == '0) ? S_PUT : S_FIND;
          ra = '0;
        end
      end
      S_CSCAN: begin
        // i_q: index read now, one above the entry in rd_q ; j_q: write pointer
        if (i_q != '0 && !rd_hit_c) begin
          we = 1'b1; wa = j_a; wd = rd_q;
        end
        if (i_q == occ_q) state_d = S_DONE;
        else ra = i_a;
      end
      S_DONE: state_d = out_free ? S_IDLE : S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (take_req) begin
        cur_q <= req.data;
        rsp_q <= '0;
        ins_q <= '{start: req.data.time_us, dur: req.data.duration_us,
                   prio: req.data.priority_req, period: req.data.repeat_us,
                   target: req.data.recipient, handle: req.data.packet_handle,
                   ident: idc_q};
        i_q <= '0; j_q <= occ_q; pos_q <= '0; cnt_q <= '0;
        seen_q <= '0;
        unique case (req.data.command)
          CMD_ADD: begin
            if (occ_q < CW'(TABLE_DEPTH)) rsp_q.tx_id <= idc_q;
            else rsp_q.status <= ST_FULL;
            pos_q <= occ_q;
          end
          CMD_POP: if (occ_q == '0) rsp_q.status <= ST_EMPTY;
          CMD_CANCEL_ALL: rsp_q.removed_count <= 5'(occ_q);
          default: ;
        endcase
      end
      S_FIND: begin
        if (slot_hit) pos_q <= i_q;
        else i_q <= i_q + 1'b1;
        j_q <= occ_q;
      end
      S_SHIFT: j_q <= j_q - 1'b1;
      S_PSCAN: begin
        if (i_q == '0) head_q <= rd_q.start;
        if (state_d == S_PREM) begin
          ins_q <= rd_q; j_q <= i_q;
          rsp_q.status <= ST_OK; rsp_q.tx_id <= rd_q.ident;
          rsp_q.out_time_us <= rd_q.start; rsp_q.out_priority <= rd_q.prio;
          rsp_q.out_recipient <= rd_q.target; rsp_q.out_handle <= rd_q.handle;
        end else if (state_d == S_DONE) rsp_q.status <= ST_EMPTY;
        seen_q[rd_q.target] <= 1'b1;
        i_q <= i_q + 1'b1;
      end
      S_PREM: begin
        if (j_q + 1'b1 < occ_q) j_q <= j_q + 1'b1;
        dvd_q <= cur_q.time_us - ins_q.start; rem_q <= '0; dstep_q <= '0;
      end
      S_DIV: begin
        if (dstep_q != 7'd64) begin
          dstep_q <= dstep_q + 7'd1;
          dvd_q <= {dvd_q[62:0], 1'b0};
          rem_q <= rtry[64] ? {rem_q[62:0], dvd_q[63]} : rtry[63:0];
        end else begin
          ins_q.start <= adv[64] ? '1 : adv[63:0];
          rsp_q.out_time_us <= adv[64] ? '1 : adv[63:0];
          i_q <= '0; pos_q <= occ_q;
        end
      end
      S_CSCAN: begin
        if (i_q != '0) begin
          if (rd_hit_c) cnt_q <= cnt_q + 1'b1;
          else j_q <= j_q + 1'b1;
        end else j_q <= '0;
        i_q <= i_q + 1'b1;
        if (i_q == occ_q) rsp_q.removed_count <= 5'(cnt_q + CW'(rd_hit_c));
      end
      S_DONE: if (out_free) out_q <= rsp_q;
      default: ;
    endcase
  end

  `TPS_ASSERT(a_occ_le_depth, clk_i, rst_ni, occ_q <= CW'(TABLE_DEPTH), "occupancy over depth")
  `TPS_ASSERT(a_no_req_busy, clk_i, rst_ni, (state_q != S_IDLE) |-> !req.ready, "ready while busy")
  `TPS_ASSERT(a_done_valid, clk_i, rst_ni, (state_q == S_DONE) |=> rsp.valid, "result not shown")
  `TPS_ASSERT(a_put_room, clk_i, rst_ni, (state_q == S_PUT) |-> occ_q < CW'(TABLE_DEPTH), "put into full table")
endmodule
